FILE: sv/aef_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aef_pkg
// Shared types, constants and index helpers for the aging escalation FIFO.
// ----------------------------------------------------------------------------
package aef_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int ENTRY_W     = 3 * DATA_W;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] word_t;

    typedef enum logic [1:0] {
        REQ_ADD      = 2'd0,
        REQ_RESOLVE  = 2'd1,
        REQ_PEEK     = 2'd2,
        REQ_ESCALATE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_SCAN,
        S_COPY
    } state_t;

    // ring index a + b, b below QUEUE_DEPTH
    function automatic idx_t wrap_add(idx_t a, cnt_t b);
        logic [CNT_W:0] s;
        s = {1'b0, {(CNT_W-IDX_W){1'b0}}, a} + {1'b0, b};
        if (s >= (CNT_W+1)'(QUEUE_DEPTH))
            s = s - (CNT_W+1)'(QUEUE_DEPTH);
        return s[IDX_W-1:0];
    endfunction

    // ring index a - b, b at most QUEUE_DEPTH
    function automatic idx_t wrap_sub(idx_t a, cnt_t b);
        logic [CNT_W:0] s;
        s = {1'b0, {(CNT_W-IDX_W){1'b0}}, a} + (CNT_W+1)'(QUEUE_DEPTH) - {1'b0, b};
        if (s >= (CNT_W+1)'(QUEUE_DEPTH))
            s = s - (CNT_W+1)'(QUEUE_DEPTH);
        return s[IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: sv/aef_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aef_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module aef_ram #(
    parameter int AW = 6,
    parameter int DW = 96
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: sv/aging_escalation_fifo_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aging_escalation_fifo_top
// Bounded ticket queue with age-based promotion of old tickets to the front.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one request item: req_type,
// now_time, desc_handle. Output channel (out_valid / out_stall) returns one
// result item per request. cfg_wr_en / cfg_wr_data write the escalation
// threshold; write it only while the block is idle.
// One request is worked on at a time. Add is answered in the cycle after it is
// accepted; resolve and peek do one ring read and answer from S_HEAD. Escalate
// runs a scan pass over the ring RAM with one read per cycle, then a copy pass
// that writes the old tickets back in front of the head from a scratch RAM,
// one per cycle.
// A new item is taken once the previous result has been loaded and the
// output register is empty or is being drained.
// Reset empties the queue, sets the next id to 1 and the threshold to 0.
// RAM contents are not cleared; only held entries are ever read.
// While out_stall is high a pending result holds and in_stall stays high.
// ----------------------------------------------------------------------------
module aging_escalation_fifo_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           req_type,
    input  wire logic [31:0]          now_time,
    input  wire logic [31:0]          desc_handle,
    input  wire logic                 cfg_wr_en,
    input  wire logic [31:0]          cfg_wr_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                status,
    output logic [31:0]               ticket_id,
    output logic [31:0]               ticket_desc,
    output logic [31:0]               ticket_time,
    output logic [6:0]                moved_count,
    output logic [6:0]                queue_count
);
    import aef_pkg::*;

    state_t state_reg, state_next;
    idx_t   head_reg, head_next;
    cnt_t   count_reg, count_next;
    word_t  next_id_reg, next_id_next;
    word_t  thr_reg;
    word_t  now_reg, now_next;
    cnt_t   iss_reg, iss_next;
    cnt_t   nold_reg, nold_next;
    cnt_t   nyng_reg, nyng_next;
    logic   pend_reg, pend_next;

    logic        ov_reg, ov_next;
    logic [1:0]  st_reg, st_next;
    word_t       id_reg, id_next;
    word_t       desc_reg, desc_next;
    word_t       time_reg, time_next;
    cnt_t        mv_reg, mv_next;
    cnt_t        qc_reg, qc_next;

    logic                ring_we, ring_re, scr_we, scr_re;
    idx_t                ring_waddr, ring_raddr, scr_waddr, scr_raddr;
    logic [ENTRY_W-1:0]  ring_wdata, ring_rdata, scr_rdata;
    logic                accept;
    word_t               age;

    aef_ram #(.AW(IDX_W), .DW(ENTRY_W)) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // old tickets in scan order
    aef_ram #(.AW(IDX_W), .DW(ENTRY_W)) u_scratch (
        .clk   (clk),
        .we    (scr_we),
        .waddr (scr_waddr),
        .wdata (ring_rdata),
        .re    (scr_re),
        .raddr (scr_raddr),
        .rdata (scr_rdata)
    );

    assign in_stall    = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign accept      = in_valid && !in_stall;
    assign age         = now_reg - ring_rdata[DATA_W-1:0];
    assign out_valid   = ov_reg;
    assign status      = st_reg;
    assign ticket_id   = id_reg;
    assign ticket_desc = desc_reg;
    assign ticket_time = time_reg;
    assign moved_count = 7'(mv_reg);
    assign queue_count = 7'(qc_reg);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        next_id_next = next_id_reg;
        now_next     = now_reg;
        iss_next     = iss_reg;
        nold_next    = nold_reg;
        nyng_next    = nyng_reg;
        pend_next    = 1'b0;
        ov_next      = ov_reg && out_stall;
        st_next      = st_reg;
        id_next      = id_reg;
        desc_next    = desc_reg;
        time_next    = time_reg;
        mv_next      = mv_reg;
        qc_next      = qc_reg;
        ring_we      = 1'b0;
        ring_waddr   = wrap_add(head_reg, count_reg);
        ring_wdata   = {next_id_reg, desc_handle, now_time};
        ring_re      = 1'b0;
        ring_raddr   = head_reg;
        scr_we       = 1'b0;
        scr_waddr    = nold_reg[IDX_W-1:0];
        scr_re       = 1'b0;
        scr_raddr    = iss_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next  = now_time;
                    st_next   = STAT_OK;
                    id_next   = '0;
                    desc_next = '0;
                    time_next = '0;
                    mv_next   = '0;
                    unique case (req_t'(req_type))
                        REQ_ADD:
                        begin
                            ov_next = 1'b1;
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                st_next = STAT_FULL;
                                qc_next = count_reg;
                            end
                            else
                            begin
                                ring_we      = 1'b1;
                                id_next      = next_id_reg;
                                next_id_next = next_id_reg + 32'd1;
                                count_next   = count_reg + CNT_W'(1);
                                qc_next      = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_RESOLVE, REQ_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                ov_next = 1'b1;
                                st_next = STAT_EMPTY;
                                qc_next = count_reg;
                            end
                            else
                            begin
                                ring_re    = 1'b1;
                                state_next = S_HEAD;
                                if (req_t'(req_type) == REQ_RESOLVE)
                                begin
                                    head_next  = wrap_add(head_reg, CNT_W'(1));
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        REQ_ESCALATE:
                        begin
                            iss_next   = '0;
                            nold_next  = '0;
                            nyng_next  = '0;
                            state_next = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_HEAD:
            begin
                ov_next    = 1'b1;
                id_next    = ring_rdata[3*DATA_W-1:2*DATA_W];
                desc_next  = ring_rdata[2*DATA_W-1:DATA_W];
                time_next  = ring_rdata[DATA_W-1:0];
                qc_next    = count_reg;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (iss_reg < count_reg)
                begin
                    ring_re    = 1'b1;
                    ring_raddr = wrap_add(head_reg, iss_reg);
                    iss_next   = iss_reg + CNT_W'(1);
                    pend_next  = 1'b1;
                end
                if (pend_reg)
                begin
                    if (age >= thr_reg)
                    begin
                        scr_we    = 1'b1;
                        nold_next = nold_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // young tickets compact toward the head; never ahead of the read
                        ring_we    = 1'b1;
                        ring_waddr = wrap_add(head_reg, nyng_reg);
                        ring_wdata = ring_rdata;
                        nyng_next  = nyng_reg + CNT_W'(1);
                    end
                end
                else if (iss_reg == count_reg)
                begin
                    iss_next   = '0;
                    nyng_next  = '0;
                    state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                // old ticket k goes to head-1-k, so the new head sees them reversed
                if (iss_reg < nold_reg)
                begin
                    scr_re    = 1'b1;
                    iss_next  = iss_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    ring_we    = 1'b1;
                    ring_waddr = wrap_sub(head_reg, nyng_reg + CNT_W'(1));
                    ring_wdata = scr_rdata;
                    nyng_next  = nyng_reg + CNT_W'(1);
                end
                else if (iss_reg == nold_reg)
                begin
                    head_next  = wrap_sub(head_reg, nold_reg);
                    ov_next    = 1'b1;
                    mv_next    = nold_reg;
                    qc_next    = count_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            next_id_reg <= 32'd1;
            thr_reg     <= '0;
            pend_reg    <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            next_id_reg <= next_id_next;
            pend_reg    <= pend_next;
            ov_reg      <= ov_next;
            if (cfg_wr_en)
                thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        iss_reg  <= iss_next;
        nold_reg <= nold_next;
        nyng_reg <= nyng_next;
        st_reg   <= st_next;
        id_reg   <= id_next;
        desc_reg <= desc_next;
        time_reg <= time_next;
        mv_reg   <= mv_next;
        qc_reg   <= qc_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("ticket count above depth");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req_type == REQ_ADD && count_reg != CNT_W'(QUEUE_DEPTH)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("add did not grow the queue");

    a_scan_split: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> (nold_reg + nyng_reg) <= count_reg)
        else $error("scan split exceeds count");

    a_esc_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN || state_reg == S_COPY |=> count_reg == $past(count_reg))
        else $error("escalate changed the count");

endmodule
`default_nettype wire
